// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

    localparam int WIDTH  = 32;
    localparam int WIDE_W = 2 * WIDTH;
    localparam int CNT_W  = $clog2(WIDE_W);

    localparam logic [2:0] FUNC_NORM = 3'd0;
    localparam logic [2:0] FUNC_ADD  = 3'd1;
    localparam logic [2:0] FUNC_SUB  = 3'd2;
    localparam logic [2:0] FUNC_MUL  = 3'd3;
    localparam logic [2:0] FUNC_DIV  = 3'd4;
    localparam logic [2:0] FUNC_CMP  = 3'd5;
    localparam logic [2:0] FUNC_NEG  = 3'd6;
    localparam logic [2:0] FUNC_RSVD = 3'd7;

    localparam logic [1:0] MUL_STEPS = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       form;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic gcd_done;
    } status_t;

endpackage

// ===== rtl/core/rau_ctrl.sv =====
module rau_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  rau_pkg::status_t status,
    output rau_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FORM,
        S_GCD,
        S_DIV,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [rau_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cnt_reg[1:0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == rau_pkg::MUL_STEPS)
                    state_next = S_FORM;
            end
            S_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == {rau_pkg::CNT_W{1'b1}})
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/rau_datapath.sv =====
module rau_datapath
(
    input  logic                      clk,
    input  rau_pkg::cmd_t             cmd,
    output rau_pkg::status_t          status,
    input  logic [2:0]                func,
    input  logic signed [31:0]        a_num,
    input  logic signed [31:0]        a_den,
    input  logic signed [31:0]        b_num,
    input  logic signed [31:0]        b_den,
    output logic signed [31:0]        res_num,
    output logic [30:0]               res_den,
    output logic                      less,
    output logic                      equal,
    output logic                      div_zero,
    output logic                      overflow
);

    localparam int W  = rau_pkg::WIDTH;
    localparam int WW = rau_pkg::WIDE_W;
    localparam logic [WW-1:0] HALF = WW'(1) << (W - 1);

    // operand magnitudes and signs
    logic [2:0]   func_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic         an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;

    logic [WW-1:0] p0_reg, p1_reg, p2_reg;
    logic [W-1:0]  mul_x, mul_y;
    logic [WW-1:0] mul_p;

    logic          neg_reg, chk_reg, lt_reg, eq_reg, dz_reg;
    logic [WW-1:0] num_reg, den_reg;
    logic [WW-1:0] gx_reg, gy_reg, g_reg;
    logic [5:0]    gk_reg;
    logic [WW-1:0] qn_reg, qd_reg, rn_reg, rd_reg;

    logic [WW-1:0] res_num_wide;
    logic [30:0]   res_den_reg;
    logic signed [31:0] res_num_reg;
    logic          lt_out_reg, eq_out_reg, dz_out_reg, ovf_out_reg;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // load
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            an_reg   <= mag(a_num[W-1:0]);
            ad_reg   <= mag(a_den[W-1:0]);
            bn_reg   <= mag(b_num[W-1:0]);
            bd_reg   <= mag(b_den[W-1:0]);
            an_s_reg <= a_num[W-1];
            ad_s_reg <= a_den[W-1];
            bn_s_reg <= b_num[W-1];
            bd_s_reg <= b_den[W-1];
        end
    end

    // shared multiplier, one product per cycle
    always_comb
    begin
        case (cmd.mul_sel)
            2'd0:
            begin
                mul_x = an_reg;
                mul_y = (func_reg == rau_pkg::FUNC_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
            end
            default:
            begin
                mul_x = ad_reg;
                mul_y = bd_reg;
            end
        endcase
        mul_p = WW'(mul_x) * WW'(mul_y);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                2'd0:    p0_reg <= mul_p;
                2'd1:    p1_reg <= mul_p;
                default: p2_reg <= mul_p;
            endcase
        end
    end

    // form the unreduced result and the flags
    logic          a_neg, b_neg, sb, uses_b, zden;
    logic signed [WW-1:0] lval, rval;
    logic          f_neg, f_chk, f_lt, f_eq, f_dz;
    logic [WW-1:0] f_num, f_den;

    always_comb
    begin
        a_neg  = an_s_reg ^ ad_s_reg;
        b_neg  = bn_s_reg ^ bd_s_reg;
        sb     = (func_reg == rau_pkg::FUNC_SUB) ? !b_neg : b_neg;
        uses_b = (func_reg >= rau_pkg::FUNC_ADD) && (func_reg <= rau_pkg::FUNC_CMP);
        zden   = (ad_reg == '0) || (uses_b && (bd_reg == '0));
        lval   = a_neg ? -$signed(p0_reg) : $signed(p0_reg);
        rval   = b_neg ? -$signed(p1_reg) : $signed(p1_reg);
        f_neg  = 1'b0;
        f_num  = '0;
        f_den  = WW'(1);
        f_chk  = 1'b0;
        f_lt   = 1'b0;
        f_eq   = 1'b0;
        f_dz   = 1'b0;
        if (func_reg == rau_pkg::FUNC_RSVD)
        begin
            f_dz = 1'b0;
        end
        else if (zden)
            f_dz = 1'b1;
        else
        begin
            case (func_reg)
                rau_pkg::FUNC_NORM:
                begin
                    f_neg = a_neg;
                    f_num = WW'(an_reg);
                    f_den = WW'(ad_reg);
                    f_chk = 1'b1;
                end
                rau_pkg::FUNC_NEG:
                begin
                    f_neg = !a_neg;
                    f_num = WW'(an_reg);
                    f_den = WW'(ad_reg);
                    f_chk = 1'b1;
                end
                rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB:
                begin
                    if (a_neg == sb)
                    begin
                        f_neg = a_neg;
                        f_num = p0_reg + p1_reg;
                    end
                    else if (p0_reg >= p1_reg)
                    begin
                        f_neg = a_neg;
                        f_num = p0_reg - p1_reg;
                    end
                    else
                    begin
                        f_neg = sb;
                        f_num = p1_reg - p0_reg;
                    end
                    f_den = p2_reg;
                    f_chk = 1'b1;
                end
                rau_pkg::FUNC_MUL:
                begin
                    f_neg = a_neg ^ b_neg;
                    f_num = p0_reg;
                    f_den = p2_reg;
                    f_chk = 1'b1;
                end
                rau_pkg::FUNC_DIV:
                begin
                    if (bn_reg == '0)
                        f_dz = 1'b1;
                    else
                    begin
                        f_neg = a_neg ^ b_neg;
                        f_num = p0_reg;
                        f_den = p1_reg;
                        f_chk = 1'b1;
                    end
                end
                default:
                begin
                    f_lt = lval < rval;
                    f_eq = lval == rval;
                end
            endcase
        end
    end

    // binary gcd, one step per cycle
    logic          gx_odd, gy_odd;
    assign gx_odd = gx_reg[0];
    assign gy_odd = gy_reg[0];
    assign status.gcd_done = (gx_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.form)
        begin
            neg_reg <= f_neg;
            num_reg <= f_num;
            den_reg <= f_den;
            chk_reg <= f_chk;
            lt_reg  <= f_lt;
            eq_reg  <= f_eq;
            dz_reg  <= f_dz;
            gx_reg  <= f_num;
            gy_reg  <= f_den;
            gk_reg  <= '0;
        end
        else if (cmd.gcd_step)
        begin
            if (!gx_odd && !gy_odd)
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 1'b1;
            end
            else if (!gx_odd)
                gx_reg <= gx_reg >> 1;
            else if (!gy_odd)
                gy_reg <= gy_reg >> 1;
            else if (gx_reg >= gy_reg)
                gx_reg <= (gx_reg - gy_reg) >> 1;
            else
                gy_reg <= (gy_reg - gx_reg) >> 1;
        end
    end

    // two restoring dividers sharing the divisor
    logic [WW:0] tn, td;
    assign tn = {rn_reg, qn_reg[WW-1]};
    assign td = {rd_reg, qd_reg[WW-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            g_reg  <= gy_reg << gk_reg;
            qn_reg <= num_reg;
            qd_reg <= den_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (tn >= {1'b0, g_reg})
            begin
                rn_reg <= WW'(tn - {1'b0, g_reg});
                qn_reg <= {qn_reg[WW-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= tn[WW-1:0];
                qn_reg <= {qn_reg[WW-2:0], 1'b0};
            end
            if (td >= {1'b0, g_reg})
            begin
                rd_reg <= WW'(td - {1'b0, g_reg});
                qd_reg <= {qd_reg[WW-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= td[WW-1:0];
                qd_reg <= {qd_reg[WW-2:0], 1'b0};
            end
        end
    end

    // output register
    logic o_neg, o_ovf;
    always_comb
    begin
        o_neg        = neg_reg && (qn_reg != '0);
        o_ovf        = chk_reg && ((o_neg ? (qn_reg > HALF) : (qn_reg > HALF - 1'b1))
                       || (qd_reg > HALF - 1'b1));
        res_num_wide = o_neg ? (~qn_reg + 1'b1) : qn_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_num_reg <= 32'($signed(res_num_wide[W-1:0]));
            res_den_reg <= qd_reg[30:0] & 31'(HALF - 1'b1);
            lt_out_reg  <= lt_reg;
            eq_out_reg  <= eq_reg;
            dz_out_reg  <= dz_reg;
            ovf_out_reg <= o_ovf;
        end
    end

    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign less     = lt_out_reg;
    assign equal    = eq_out_reg;
    assign div_zero = dz_out_reg;
    assign overflow = ovf_out_reg;

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// rational arithmetic unit: takes one request (func plus fractions a and b) at a time and
// returns one reduced fraction with flags. a request runs three products on the shared 32x32
// multiplier, forms the unreduced result, then runs the binary gcd loop one shift or subtract
// a cycle (at most about 128 steps, fewer for small operands), then two bit-serial dividers
// run side by side to divide the numerator and denominator by the gcd.
// the next request is taken while a finished result still waits in the output register
module rational_arithmetic_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         func,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic               less,
    output logic               equal,
    output logic               div_zero,
    output logic               overflow
);

    rau_pkg::cmd_t    cmd;
    rau_pkg::status_t status;

    // sequencing and handshake
    rau_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // multiplier, gcd and dividers
    rau_datapath u_datapath
    (
        .clk      (clk),
        .cmd      (cmd),
        .status   (status),
        .func     (func),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .res_num  (res_num),
        .res_den  (res_den),
        .less     (less),
        .equal    (equal),
        .div_zero (div_zero),
        .overflow (overflow)
    );

endmodule

// ===== rtl/core/rau_checker.sv =====
module rau_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] res_num,
    input logic [30:0]        res_den,
    input logic               less,
    input logic               equal,
    input logic               div_zero,
    input logic               overflow
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den))
        else $error("stalled result changed");

    // a denominator that fits is never zero
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow |-> res_den != '0)
        else $error("zero denominator");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> res_num == '0 && res_den == 31'd1 && !overflow)
        else $error("bad zero-divide result");

    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (less || equal) |-> !(less && equal) && !overflow && !div_zero)
        else $error("bad compare flags");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_num   (res_num),
    .res_den   (res_den),
    .less      (less),
    .equal     (equal),
    .div_zero  (div_zero),
    .overflow  (overflow)
);
